@@ hw/rtl/iwn_pkg.sv @@
// shared types, constants and helper functions for the iso week number pipeline
package iwn_pkg;

    // reciprocal of 25 scaled by 2^16, exact for dividends below 4096
    localparam logic [11:0] RECIP25       = 12'd2622;
    localparam int          RECIP25_SHIFT = 16;

    // month codes used in the boundary tests
    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_MAR = 4'd3;
    localparam logic [3:0] MON_DEC = 4'd12;

    // weekday codes, monday is zero
    localparam logic [2:0] WD_THU = 3'd3;
    localparam logic [2:0] WD_SUN = 3'd6;

    localparam logic [4:0] DAY_LAST_DEC = 5'd31;
    localparam logic [5:0] WEEK_LEN     = 6'd7;

    // per-date values handed from the weekday stage to the week stage
    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
        logic [2:0] wd_date;
        logic [2:0] wd_jan1;
        logic [2:0] wd_jan1_prev;
        logic [2:0] wd_jan1_next;
    } iwn_info_t;

    // residue mod 7 by folding octal digits (8 is 1 mod 7)
    function automatic logic [2:0] mod7(input logic [14:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [2:0] s3;
        begin
            s1 = {3'b0, x[14:12]} + {3'b0, x[11:9]} + {3'b0, x[8:6]}
               + {3'b0, x[5:3]} + {3'b0, x[2:0]};
            s2 = {1'b0, s1[5:3]} + {1'b0, s1[2:0]};
            s3 = 3'(s2[2:0] + {2'b0, s2[3]});
            mod7 = (s3 == 3'd7) ? 3'd0 : s3;
        end
    endfunction

    // month part of the weekday sum, mod 7, with jan/feb (and month 0) as months 13/14/12
    function automatic logic [2:0] month_term(input logic [3:0] m);
        begin
            case (m)
                4'd0:    month_term = 3'd3;
                4'd1:    month_term = 3'd6;
                4'd2:    month_term = 3'd2;
                4'd3:    month_term = 3'd1;
                4'd4:    month_term = 3'd4;
                4'd5:    month_term = 3'd6;
                4'd6:    month_term = 3'd2;
                4'd7:    month_term = 3'd4;
                4'd8:    month_term = 3'd0;
                4'd9:    month_term = 3'd3;
                4'd10:   month_term = 3'd5;
                4'd11:   month_term = 3'd1;
                4'd12:   month_term = 3'd3;
                4'd13:   month_term = 3'd6;
                4'd14:   month_term = 3'd2;
                default: month_term = 3'd4;
            endcase
        end
    endfunction

endpackage

@@ hw/rtl/iwn_year_term.sv @@
// three-stage lane: (y + y/4 - y/100 + y/400) mod 7 for one year value
module iwn_year_term (
    input  logic        clk,
    input  logic [14:0] year,
    output logic [2:0]  term
);

    logic [23:0] prod;
    logic [13:0] ya_reg;
    logic [11:0] q4a_reg;
    logic [7:0]  c100a_reg;
    logic        nega_reg;
    logic [2:0]  nresa_reg;
    logic [14:0] sumb_reg;
    logic [14:0] sumb_next;
    logic        negb_reg;
    logic [2:0]  nresb_reg;
    logic [2:0]  term_reg;

    // y/100 as (y/4)/25 through the scaled reciprocal
    assign prod = 24'(year[13:2]) * 24'(iwn_pkg::RECIP25);

    // stage a: quarter and century counts
    // years just below zero: every quotient truncates to zero, so the term is the year itself
    always_ff @(posedge clk)
    begin
        ya_reg    <= year[13:0];
        q4a_reg   <= year[13:2];
        c100a_reg <= prod[iwn_pkg::RECIP25_SHIFT +: 8];
        nega_reg  <= year[14];
        nresa_reg <= year[2:0] - 3'd1;
    end

    // stage b: leap-day corrected year sum
    assign sumb_next = {1'b0, ya_reg} + {3'b0, q4a_reg} - {7'b0, c100a_reg}
                     + {9'b0, c100a_reg[7:2]};

    always_ff @(posedge clk)
    begin
        sumb_reg  <= sumb_next;
        negb_reg  <= nega_reg;
        nresb_reg <= nresa_reg;
    end

    // stage c: reduce mod 7
    always_ff @(posedge clk)
    begin
        term_reg <= negb_reg ? nresb_reg : iwn_pkg::mod7(sumb_reg);
    end

    assign term = term_reg;

endmodule

@@ hw/rtl/iwn_weekday.sv @@
// weekday stage: weekday of the date and of the neighboring 1 january dates
module iwn_weekday (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [3:0]          month,
    input  logic [4:0]          day,
    input  logic [2:0]          term_cur,
    input  logic [2:0]          term_prev,
    input  logic [2:0]          term_prev2,
    output logic                out_valid,
    output iwn_pkg::iwn_info_t  info
);

    logic [2:0]          fsel;
    logic [5:0]          wsum;
    logic                valid_reg;
    iwn_pkg::iwn_info_t  info_reg;
    iwn_pkg::iwn_info_t  info_next;

    // jan/feb count in the year before
    assign fsel = (month < iwn_pkg::MON_MAR) ? term_prev : term_cur;
    assign wsum = {1'b0, day} + {3'b0, iwn_pkg::month_term(month)} + {3'b0, fsel};

    // 1 january of year y uses the year term of y-1 (day 1 plus month term 6 is 0 mod 7)
    always_comb
    begin
        info_next.month        = month;
        info_next.day          = day;
        info_next.wd_date      = iwn_pkg::mod7(15'(wsum));
        info_next.wd_jan1      = term_prev;
        info_next.wd_jan1_prev = term_prev2;
        info_next.wd_jan1_next = term_cur;
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        info_reg <= info_next;
    end

    assign out_valid = valid_reg;
    assign info      = info_reg;

endmodule

@@ hw/rtl/iwn_week_calc.sv @@
// week stage: boundary cases and the week number approximation
module iwn_week_calc (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  iwn_pkg::iwn_info_t  info,
    output logic                done,
    output logic [5:0]          week_number
);

    logic       prev_year;
    logic       next_year;
    logic [3:0] em;
    logic [4:0] ed;
    logic [2:0] ew1;
    logic [2:0] ew;
    logic [8:0] t;
    logic [11:0] t36;
    logic [3:0] q;
    logic       early_week;
    logic [5:0] week_next;
    logic       done_reg;
    logic [5:0] week_reg;

    // early january in the last week of the previous year
    assign prev_year = (info.month == iwn_pkg::MON_JAN)
                     && (info.wd_jan1 > iwn_pkg::WD_THU)
                     && (({3'b0, info.wd_jan1} + {1'b0, info.day}) <= iwn_pkg::WEEK_LEN);

    // late december already in week 1 of the next year
    assign next_year = (info.month == iwn_pkg::MON_DEC)
                     && ((iwn_pkg::DAY_LAST_DEC - info.day) < {2'b0, info.wd_jan1_next})
                     && (info.wd_jan1_next <= iwn_pkg::WD_THU);

    // date actually evaluated: 31 december of the previous year when shifted
    assign em  = prev_year ? iwn_pkg::MON_DEC : info.month;
    assign ed  = prev_year ? iwn_pkg::DAY_LAST_DEC : info.day;
    assign ew1 = prev_year ? info.wd_jan1_prev : info.wd_jan1;
    assign ew  = prev_year ? (info.wd_jan1 - 3'd1) : info.wd_date;

    // day offset term, may dip just below zero for malformed dates
    assign t = {4'b0, em, 1'b0} + {4'b0, ed} + {6'b0, ew1} - {6'b0, ew} + 9'd3;

    // times 36, over 256, truncating toward zero
    assign t36 = {t[6:0], 5'b0} + {3'b0, t[6:0], 2'b0};
    assign q   = t[8] ? 4'd0 : t36[11:8];

    assign early_week = (ew1 <= iwn_pkg::WD_THU);
    assign week_next  = next_year ? 6'd1
                      : ({5'b0, early_week} + {em, 2'b0} - 6'd4 + {2'b0, q});

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        week_reg <= week_next;
    end

    assign done        = done_reg;
    assign week_number = week_reg;

endmodule

@@ hw/rtl/iso_week_number.sv @@
// top level of the iso 8601 week number pipeline
// One date enters per clock: start is taken whenever busy is low, and busy never rises.
// The week number appears on week_number with done high once the request has passed
// the six register stages (input register, three year-term stages doing the
// divide-by-25 multiply and the mod 7 fold, the weekday stage and the output register).
// Results are shown for one cycle only and are not held.
module iso_week_number (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [13:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    output logic        done,
    output logic [5:0]  week_number
);

    localparam int LANE_DEPTH = 3;

    logic                v0_reg;
    logic [13:0]         yr_reg;
    logic [3:0]          mon_reg;
    logic [4:0]          dd_reg;
    logic [LANE_DEPTH-1:0] vpipe_reg;
    logic [3:0]          mpipe_reg [LANE_DEPTH];
    logic [4:0]          dpipe_reg [LANE_DEPTH];
    logic [2:0]          term_cur;
    logic [2:0]          term_prev;
    logic [2:0]          term_prev2;
    logic                wd_valid;
    iwn_pkg::iwn_info_t  wd_info;

    assign busy = 1'b0;

    // input stage valid and side pipe valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            vpipe_reg <= '0;
        end
        else
        begin
            v0_reg    <= start && !busy;
            vpipe_reg <= {vpipe_reg[LANE_DEPTH-2:0], v0_reg};
        end
    end

    // request payload and month/day delay alongside the year lanes
    always_ff @(posedge clk)
    begin
        yr_reg       <= year;
        mon_reg      <= month;
        dd_reg       <= day;
        mpipe_reg[0] <= mon_reg;
        dpipe_reg[0] <= dd_reg;
        for (int i = 1; i < LANE_DEPTH; i++)
        begin
            mpipe_reg[i] <= mpipe_reg[i-1];
            dpipe_reg[i] <= dpipe_reg[i-1];
        end
    end

    // year terms for y, y-1 and y-2
    iwn_year_term u_term_cur (
        .clk  (clk),
        .year ({1'b0, yr_reg}),
        .term (term_cur)
    );

    iwn_year_term u_term_prev (
        .clk  (clk),
        .year ({1'b0, yr_reg} - 15'd1),
        .term (term_prev)
    );

    iwn_year_term u_term_prev2 (
        .clk  (clk),
        .year ({1'b0, yr_reg} - 15'd2),
        .term (term_prev2)
    );

    // weekday stage
    iwn_weekday u_weekday (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (vpipe_reg[LANE_DEPTH-1]),
        .month      (mpipe_reg[LANE_DEPTH-1]),
        .day        (dpipe_reg[LANE_DEPTH-1]),
        .term_cur   (term_cur),
        .term_prev  (term_prev),
        .term_prev2 (term_prev2),
        .out_valid  (wd_valid),
        .info       (wd_info)
    );

    // week stage and output register
    iwn_week_calc u_week_calc (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (wd_valid),
        .info        (wd_info),
        .done        (done),
        .week_number (week_number)
    );

endmodule

@@ hw/rtl/iwn_checker.sv @@
// port-level checks for the iso week number pipeline, bound to the top level
module iwn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [13:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic        done,
    input logic [5:0]  week_number
);

    // every request produces a result
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("request without result");

    // no result without an earlier request
    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("result without request");

    // identical back-to-back dates give identical week numbers
    a_same_date: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done) && ($past(year, 6) == $past(year, 7))
            && ($past(month, 6) == $past(month, 7)) && ($past(day, 6) == $past(day, 7)))
        |-> $stable(week_number))
        else $error("week number misaligned with its request");

endmodule

bind iso_week_number iwn_checker u_iwn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .year        (year),
    .month       (month),
    .day         (day),
    .done        (done),
    .week_number (week_number)
);

@@ sim/tb.sv @@
// self-checking testbench for the iso 8601 week number pipeline
module tb;

    // weekday and date limits in signed form for the week arithmetic
    localparam int THURSDAY   = int'(iwn_pkg::WD_THU);
    localparam int DAYS_WEEK  = int'(iwn_pkg::WEEK_LEN);
    localparam int LAST_DEC   = int'(iwn_pkg::DAY_LAST_DEC);
    localparam int WEEK_SCALE = 36;
    localparam int WEEK_DIV   = 256;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int ITEMS_PER_PHASE = 610;

    typedef struct {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [5:0]  week;
    } date_week_t;

    // expected week numbers of accepted requests, oldest first
    class week_scoreboard;
        date_week_t expected_weeks[$];
        int         error_count;

        function new();
            error_count = 0;
        endfunction

        // weekday 0 = monday; jan and feb count as months 13 and 14 of the year before
        function int weekday_code(int yr, int mon, int dd);
            int sum;
            if (mon < int'(iwn_pkg::MON_MAR))
            begin
                mon += 12;
                yr -= 1;
            end
            sum = dd + 2 * mon + (6 * (mon + 1)) / 10 + yr + yr / 4 - yr / 100 + yr / 400;
            return sum % DAYS_WEEK;
        endfunction

        function logic [5:0] predict_week(logic [13:0] y, logic [3:0] m, logic [4:0] d);
            int yr;
            int mon;
            int dd;
            int wd;
            int wd_jan1;
            int wd_next;
            int wk;
            yr = int'(y);
            mon = int'(m);
            dd = int'(d);
            wd = weekday_code(yr, mon, dd);
            wd_jan1 = weekday_code(yr, int'(iwn_pkg::MON_JAN), 1);
            // early january days in the last week of the previous year
            if (mon == int'(iwn_pkg::MON_JAN) && wd_jan1 > THURSDAY
                && wd_jan1 < DAYS_WEEK - (dd - 1))
            begin
                wd = wd_jan1 - 1;
                wd_jan1 = weekday_code(yr - 1, int'(iwn_pkg::MON_JAN), 1);
                mon = int'(iwn_pkg::MON_DEC);
                dd = LAST_DEC;
            end
            // late december days in week 1 of the next year
            else if (mon == int'(iwn_pkg::MON_DEC))
            begin
                wd_next = weekday_code(yr + 1, int'(iwn_pkg::MON_JAN), 1);
                if ((30 - (dd - 1)) < wd_next && wd_next <= THURSDAY)
                    return 6'd1;
            end
            wk = (wd_jan1 <= THURSDAY ? 1 : 0) + 4 * (mon - 1)
               + ((2 * (mon - 1) + (dd - 1) + wd_jan1 - wd + 6) * WEEK_SCALE) / WEEK_DIV;
            return wk[5:0];
        endfunction

        function void note_request(logic [13:0] y, logic [3:0] m, logic [4:0] d);
            date_week_t entry;
            entry.year = y;
            entry.month = m;
            entry.day = d;
            entry.week = predict_week(y, m, d);
            expected_weeks.push_back(entry);
        endfunction

        function void check_week(logic [5:0] actual);
            date_week_t entry;
            if (expected_weeks.size() == 0)
            begin
                $error("week_number %0d arrived with no request pending", actual);
                error_count++;
                return;
            end
            entry = expected_weeks.pop_front();
            if (actual !== entry.week)
            begin
                $error("week_number for %0d-%0d-%0d: expected %0d, actual %0d",
                       entry.year, entry.month, entry.day, entry.week, actual);
                error_count++;
            end
        endfunction

        function int pending_count();
            return expected_weeks.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        done;
    logic [5:0]  week_number;

    week_scoreboard sb;
    int idle_pct;
    int stall_cycles;

    iso_week_number u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .year        (year),
        .month       (month),
        .day         (day),
        .done        (done),
        .week_number (week_number)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_week(week_number);
    end

    // watchdog on cycles with no request and no result
    initial stall_cycles = 0;
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles + 1 >= STALL_LIMIT)
        begin
            $display("FAIL iso_week_number");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic int days_in_month(int y, int m);
        bit leap;
        leap = (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
        if (m == 2)
            return leap ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // one request, entered and left at a falling edge
    task automatic send_request(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d);
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
            start <= 1'b1;
            year <= y;
            month <= m;
            day <= d;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            sb.note_request(y, m, d);
            @(negedge clk);
        end
    endtask

    // random date: mostly valid, many near the year boundary, some raw bit patterns
    task automatic send_random_date();
        int kind;
        int y;
        int m;
        int d;
        begin
            kind = $urandom_range(99);
            y = ($urandom_range(19) == 0) ? ($urandom_range(1) ? 1 : 9999)
                                          : $urandom_range(9999, 1);
            if (kind < 60)
            begin
                m = $urandom_range(12, 1);
                d = $urandom_range(days_in_month(y, m), 1);
            end
            else if (kind < 85)
            begin
                if ($urandom_range(1))
                begin
                    m = int'(iwn_pkg::MON_JAN);
                    d = $urandom_range(7, 1);
                end
                else
                begin
                    m = int'(iwn_pkg::MON_DEC);
                    d = $urandom_range(31, 25);
                end
            end
            else
            begin
                y = $urandom_range(16383);
                m = $urandom_range(15);
                d = $urandom_range(31);
            end
            send_request(y[13:0], m[3:0], d[4:0]);
        end
    endtask

    initial
    begin
        sb = new();
        idle_pct = 21;
        rst_n = 1'b0;
        start = 1'b0;
        year = '0;
        month = '0;
        day = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // field extremes and both year boundary cases
        send_request(14'd1, 4'd1, 5'd1);
        send_request(14'd9999, 4'd12, 5'd31);
        send_request(14'd0, 4'd0, 5'd0);
        send_request(14'd16383, 4'd15, 5'd31);
        send_request(14'd0, 4'd1, 5'd1);
        send_request(14'd8192, 4'd2, 5'd30);
        send_request(14'd2021, 4'd1, 5'd1);
        send_request(14'd2021, 4'd1, 5'd3);
        send_request(14'd2021, 4'd1, 5'd4);
        send_request(14'd2022, 4'd1, 5'd1);
        send_request(14'd2023, 4'd1, 5'd1);
        send_request(14'd2016, 4'd1, 5'd3);
        send_request(14'd2024, 4'd12, 5'd30);
        send_request(14'd2024, 4'd12, 5'd29);
        send_request(14'd2025, 4'd12, 5'd29);
        send_request(14'd2019, 4'd12, 5'd30);
        send_request(14'd2020, 4'd12, 5'd31);
        send_request(14'd2015, 4'd12, 5'd31);
        send_request(14'd2004, 4'd12, 5'd31);
        send_request(14'd2000, 4'd2, 5'd29);
        send_request(14'd1900, 4'd2, 5'd28);
        send_request(14'd2026, 4'd7, 5'd15);

        // sender idles often, then heavily, then never
        repeat (ITEMS_PER_PHASE) send_random_date();
        idle_pct = 50;
        repeat (ITEMS_PER_PHASE) send_random_date();
        idle_pct = 0;
        repeat (ITEMS_PER_PHASE) send_random_date();
        start <= 1'b0;

        // drain
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.error_count == 0)
            $display("PASS iso_week_number");
        else
            $display("FAIL iso_week_number");
        $finish;
    end

endmodule
